/* rtl/core/positional_insert_list_macros.svh */
// assertion macros shared by the list rtl
`ifndef POSITIONAL_INSERT_LIST_MACROS_SVH
`define POSITIONAL_INSERT_LIST_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PIL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pli_pkg.sv */
// shared types and codes for the positional insert list
package pli_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 3;
  localparam int STAT_W       = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_LOAD     = 4'd1,
    DP_START_UP = 4'd2,
    DP_RD_UP    = 4'd3,
    DP_WR_UP    = 4'd4,
    DP_START_DN = 4'd5,
    DP_RD_DN    = 4'd6,
    DP_WR_DN    = 4'd7,
    DP_RD_POS   = 4'd8,
    DP_FINISH   = 4'd9
  } dp_op_t;

  // how a request is carried out
  typedef enum logic [1:0] {
    PATH_FIN = 2'd0,
    PATH_UP  = 2'd1,
    PATH_DN  = 2'd2,
    PATH_RD  = 2'd3
  } path_t;

  typedef struct packed {
    path_t path;
    logic  more_up;
    logic  more_dn;
  } dp_stat_t;

endpackage

/* rtl/core/pli_datapath.sv */
// element store, item registers, move cursor and result register
`include "positional_insert_list_macros.svh"

module pli_datapath #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pli_pkg::REQ_W-1:0]         req_type,
  input  logic [CNT_W-1:0]                  position,
  input  logic signed [pli_pkg::DATA_W-1:0] value,
  input  pli_pkg::dp_op_t                   cmd,
  output pli_pkg::dp_stat_t                 stat,
  output logic [pli_pkg::STAT_W-1:0]        res_status,
  output logic signed [pli_pkg::DATA_W-1:0] res_read_value,
  output logic [CNT_W-1:0]                  res_count
);
  import pli_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [REQ_W-1:0]         req_r;
  logic [CNT_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic [DATA_W-1:0]        rdata_r;
  logic [STAT_W-1:0]        res_status_r;
  logic signed [DATA_W-1:0] res_rd_r;
  logic [CNT_W-1:0]         res_cnt_r;

  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  at_c;
  logic [STAT_W-1:0] st_c;
  path_t             path_c;
  logic              full_c, empty_c;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign ptr_dec = ptr_r - CNT_W'(1);
  assign full_c  = (count_r == CNT_W'(CAPACITY));
  assign empty_c = (count_r == '0);

  // classify the held request against the current count
  always_comb begin
    st_c   = ST_OK;
    at_c   = count_r;
    path_c = PATH_FIN;
    unique case (req_r) inside
      REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
        if (req_r == REQ_PUSH_FRONT) begin
          at_c = '0;
        end else if (req_r == REQ_INSERT) begin
          at_c = pos_r;
        end
        if (full_c) begin
          st_c = ST_FULL;
        end else if (req_r == REQ_INSERT && pos_r > count_r) begin
          st_c = ST_RANGE;
        end else begin
          path_c = PATH_UP;
        end
      end
      REQ_POP_BACK: begin
        if (empty_c) begin
          st_c = ST_EMPTY;
        end
      end
      REQ_POP_FRONT: begin
        if (empty_c) begin
          st_c = ST_EMPTY;
        end else begin
          path_c = PATH_DN;
        end
      end
      REQ_READ: begin
        if (empty_c) begin
          st_c = ST_EMPTY;
        end else if (pos_r >= count_r) begin
          st_c = ST_RANGE;
        end else begin
          path_c = PATH_RD;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.path    = path_c;
  assign stat.more_up = (ptr_r > at_c);
  assign stat.more_dn = (ptr_r < count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd == DP_FINISH && st_c == ST_OK) begin
      unique case (req_r) inside
        REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: count_nxt = count_r + CNT_W'(1);
        REQ_POP_BACK, REQ_POP_FRONT:               count_nxt = count_r - CNT_W'(1);
        default:                                   count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    unique case (cmd)
      DP_START_UP: ptr_nxt = count_r;
      DP_WR_UP:    ptr_nxt = ptr_dec;
      DP_START_DN: ptr_nxt = CNT_W'(1);
      DP_WR_DN:    ptr_nxt = ptr_r + CNT_W'(1);
      default:     ptr_nxt = ptr_r;
    endcase
  end

  // one read and one write port on the store
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = at_c[IDX_W-1:0];
    wr_data = rdata_r;
    unique case (cmd)
      DP_RD_UP: begin
        rd_en   = 1'b1;
        rd_addr = ptr_dec[IDX_W-1:0];
      end
      DP_RD_DN: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r[IDX_W-1:0];
      end
      DP_RD_POS: begin
        rd_en = 1'b1;
      end
      DP_WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
      end
      DP_WR_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_dec[IDX_W-1:0];
      end
      DP_FINISH: begin
        wr_en   = (path_c == PATH_UP);
        wr_data = val_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd == DP_LOAD) begin
      req_r <= req_type;
      pos_r <= position;
      val_r <= value;
    end
    if (cmd == DP_FINISH) begin
      res_status_r <= st_c;
      res_rd_r     <= (path_c == PATH_RD) ? rdata_r : '0;
      res_cnt_r    <= count_nxt;
    end
  end

  assign res_status     = res_status_r;
  assign res_read_value = res_rd_r;
  assign res_count      = res_cnt_r;

  `PIL_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `PIL_ASSERT_SAME(a_up_window, cmd == DP_WR_UP, ptr_r > at_c && ptr_r < CNT_W'(CAPACITY), "upward move outside open slot window")
  `PIL_ASSERT_SAME(a_dn_window, cmd == DP_WR_DN, ptr_r != '0 && ptr_r < count_r, "downward move outside held elements")

endmodule

/* rtl/core/pli_ctrl.sv */
// request sequencer for the positional insert list
`include "positional_insert_list_macros.svh"

module pli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pli_pkg::dp_stat_t stat,
  output pli_pkg::dp_op_t   cmd
);
  import pli_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_UP_CHK = 7'b0000100,
    S_UP_WR  = 7'b0001000,
    S_DN_CHK = 7'b0010000,
    S_DN_WR  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.path)
          PATH_UP: begin
            cmd       = DP_START_UP;
            state_nxt = S_UP_CHK;
          end
          PATH_DN: begin
            cmd       = DP_START_DN;
            state_nxt = S_DN_CHK;
          end
          PATH_RD: begin
            cmd       = DP_RD_POS;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_UP_CHK: begin
        if (stat.more_up) begin
          cmd       = DP_RD_UP;
          state_nxt = S_UP_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UP_WR: begin
        cmd       = DP_WR_UP;
        state_nxt = S_UP_CHK;
      end
      S_DN_CHK: begin
        if (stat.more_dn) begin
          cmd       = DP_RD_DN;
          state_nxt = S_DN_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_WR: begin
        cmd       = DP_WR_DN;
        state_nxt = S_DN_CHK;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          cmd       = DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd == DP_FINISH) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // no word is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  `PIL_ASSERT_SAME(a_fin_slot, cmd == DP_FINISH, !out_tvalid_r || out_tready, "result register overwritten before taken")
  `PIL_ASSERT_NEXT(a_fin_valid, cmd == DP_FINISH, out_tvalid_r, "finished result not presented")
  `PIL_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second word taken while busy")

endmodule

/* rtl/core/positional_insert_list.sv */
// top level of the positional insert list: stream ports around controller and datapath
// sequence: a word is loaded in idle, classified in exec and finished in fin for read, pop back,
//   unknown and failed requests; push back also passes the up check; push front, insert and
//   pop front add a read step and a write step per moved element (insert at i moves count - i
//   elements, pop front moves count - 1), set by the single read port and single write port of
//   the element store; the next word is taken once the result is registered, while it waits
// reset: synchronous active-low rst_n empties the list and clears control; no clearing pass
module positional_insert_list #(
  parameter  int CAPACITY  = pli_pkg::CAPACITY_DEF,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_DW     = ((CNT_W + pli_pkg::DATA_W + 7) / 8) * 8,
  localparam int OUT_DW    = ((pli_pkg::DATA_W + CNT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_DW-1:0]            in_tdata,   // position, value, zero pad
  input  logic [pli_pkg::REQ_W-1:0]   in_tuser,   // req_type
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_DW-1:0]           out_tdata,  // read_value, count, zero pad
  output logic [pli_pkg::STAT_W-1:0]  out_tuser   // status
);
  import pli_pkg::*;

  // unpacked request fields
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  // controller to datapath command and datapath status back
  dp_op_t   cmd;
  dp_stat_t stat;

  // registered result fields
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] res_read_value;
  logic [CNT_W-1:0]         res_count;

  assign position = in_tdata[CNT_W-1:0];
  assign value    = in_tdata[CNT_W+DATA_W-1:CNT_W];

  // sequencer: accepts a word in idle, walks the move loop, loads the result
  pli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // element store, count and the cursor that moves elements one slot per read step and write step
  pli_datapath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_type       (in_tuser),
    .position       (position),
    .value          (value),
    .cmd            (cmd),
    .stat           (stat),
    .res_status     (res_status),
    .res_read_value (res_read_value),
    .res_count      (res_count)
  );

  // result word: read_value in the low bits, count above it, pad bits zero
  assign out_tdata = OUT_DW'({res_count, res_read_value});
  assign out_tuser = res_status;

endmodule
